// File: hdl/lcc_pkg.sv
package lcc_pkg;

	localparam int unsigned LCC_QUEUE_DEPTH = 4;

	localparam logic [7:0] CMD_SET_ADDR = 8'h80;
	localparam logic [7:0] CMD_CLEAR    = 8'h01;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_CR  = 8'h0D;

	typedef enum logic [1:0] {
		OP_ADDR,
		OP_DATA,
		OP_CLEAR,
		OP_BACKSPACE
	} op_kind_t;

	typedef struct packed {
		op_kind_t   kind;
		logic [7:0] lcd_byte;
	} op_t;

	typedef enum logic [1:0] {
		BK_FIRST,
		BK_SPACE,
		BK_ADDR2
	} bk_state_t;

endpackage

// File: hdl/lcc_front.sv
module lcc_front
	import lcc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       q_full,
	output logic       q_push,
	output op_t        q_op
);

	logic       row_q;
	logic [3:0] col_q;
	logic       nrow;
	logic [3:0] ncol;
	op_kind_t   kind;

	always_comb begin
		nrow = row_q;
		ncol = col_q;
		kind = OP_ADDR;
		case (s_tdata)
			CH_LF: begin
				nrow = ~row_q;
				ncol = 4'd0;
			end
			CH_TAB: begin
				ncol = (col_q + 4'd4) & 4'hC;
			end
			CH_VT: begin
				nrow = ~row_q;
			end
			CH_BS: begin
				kind = OP_BACKSPACE;
				if (col_q != 4'd0) begin
					ncol = col_q - 4'd1;
				end
			end
			CH_CR: begin
				ncol = 4'd0;
			end
			CH_FF: begin
				kind = OP_CLEAR;
				nrow = 1'b0;
				ncol = 4'd0;
			end
			default: begin
				kind = OP_DATA;
				ncol = col_q + 4'd1;
			end
		endcase
	end

	always_comb begin
		q_op.kind = kind;
		case (kind)
			OP_DATA:  q_op.lcd_byte = s_tdata;
			OP_CLEAR: q_op.lcd_byte = CMD_CLEAR;
			default:  q_op.lcd_byte = CMD_SET_ADDR | {1'b0, nrow, 2'b00, ncol};
		endcase
	end

	assign s_tready = ~q_full;
	assign q_push   = s_tvalid & ~q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= 1'b0;
			col_q <= 4'd0;
		end else if (q_push) begin
			row_q <= nrow;
			col_q <= ncol;
		end
	end

endmodule

// File: hdl/lcc_queue.sv
module lcc_queue
	import lcc_pkg::*;
#(
	parameter int unsigned DEPTH = LCC_QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  op_t  push_op,
	input  logic pop,
	output logic full,
	output logic empty,
	output op_t  head_op
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	op_t           mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_pop  = pop & ~empty;
	assign head_op = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hdl/lcc_back.sv
module lcc_back
	import lcc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  op_t        q_head,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast,
	output logic [1:0] m_tuser
);

	bk_state_t  state_q;
	bk_state_t  state_nx;
	logic       load;
	logic       fire;
	logic       w_data;
	logic [7:0] w_byte;
	logic       w_slow;
	logic       w_last;

	logic       m_tvalid_q;
	logic [7:0] m_byte_q;
	logic       m_data_q;
	logic       m_slow_q;
	logic       m_last_q;

	assign load = ~m_tvalid_q | m_tready;
	assign fire = load & ~q_empty;

	always_comb begin
		state_nx = state_q;
		if (fire) begin
			case (state_q)
				BK_FIRST: state_nx = (q_head.kind == OP_BACKSPACE) ? BK_SPACE : BK_FIRST;
				BK_SPACE: state_nx = BK_ADDR2;
				BK_ADDR2: state_nx = BK_FIRST;
				default:  state_nx = BK_FIRST;
			endcase
		end
	end

	always_comb begin
		w_data = 1'b0;
		w_byte = q_head.lcd_byte;
		w_slow = 1'b0;
		w_last = 1'b1;
		case (state_q)
			BK_FIRST: begin
				w_data = (q_head.kind == OP_DATA);
				w_slow = (q_head.kind == OP_CLEAR);
				w_last = (q_head.kind != OP_BACKSPACE);
			end
			BK_SPACE: begin
				w_data = 1'b1;
				w_byte = CHAR_SPACE;
				w_last = 1'b0;
			end
			BK_ADDR2: begin
				w_last = 1'b1;
			end
			default: begin
				w_last = 1'b1;
			end
		endcase
	end

	assign q_pop = fire & w_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BK_FIRST;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (load) begin
				m_tvalid_q <= ~q_empty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			m_byte_q <= w_byte;
			m_data_q <= w_data;
			m_slow_q <= w_slow;
			m_last_q <= w_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_byte_q;
	assign m_tlast  = m_last_q;
	assign m_tuser  = {m_slow_q, m_data_q};

endmodule

// File: hdl/lcd_control_char_cursor.sv
// channel  | dir | tdata            | tuser                         | tlast
// s        | in  | [7:0] char_code  | -                             | -
// m        | out | [7:0] lcd_byte   | [0] is_data, [1] slow_command | last
//
// a character is taken every cycle while the op queue has room
// each character gives one lcd write, backspace gives three
// the output stage sends one write per cycle while m_tready is high, so
// throughput is one character per cycle, lower for backspace runs
// reset puts the cursor at row 0 column 0 and empties the queue
// a stalled m side fills the queue, then s_tready drops
module lcd_control_char_cursor
	import lcc_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = LCC_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] lcd_byte
	output logic       m_tlast,
	output logic [1:0] m_tuser    // [0] is_data, [1] slow_command
);

	logic q_full;
	logic q_empty;
	logic q_push;
	logic q_pop;
	op_t  push_op;
	op_t  head_op;

	lcc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_op     (push_op)
	);

	lcc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_op (push_op),
		.pop     (q_pop),
		.full    (q_full),
		.empty   (q_empty),
		.head_op (head_op)
	);

	lcc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_head   (head_op),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

// File: hdl/lcc_checker.sv
module lcc_checker
	import lcc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [1:0] m_tuser
);

	// clear is a single command write
	a_clear_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[0] && m_tdata == CMD_CLEAR && m_tlast)
		else $error("slow write is not a lone clear command");

	// any other command is a set-address
	a_addr_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] && !m_tuser[1] |-> m_tdata[7])
		else $error("fast command without address bit");

	// backspace: address, space, address
	a_bs_space: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tuser[0] && !m_tlast
		|=> m_tvalid && m_tuser[0] && m_tdata == CHAR_SPACE && !m_tlast)
		else $error("backspace space write missing");

	a_bs_addr: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser[0] && !m_tlast
		|=> m_tvalid && !m_tuser[0] && !m_tuser[1] && m_tlast)
		else $error("backspace closing address missing");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled transfer changed");

endmodule

bind lcd_control_char_cursor lcc_checker u_lcc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

// File: test/lcd_write_checker.sv
`timescale 1ns / 100ps

module lcd_write_checker
	import lcc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tlast,
	input  logic [1:0] m_tuser,
	output int         fail_count,
	output int         writes_pending,
	output int         chars_seen,
	output int         writes_seen
);

	typedef struct packed {
		logic       is_data;
		logic [7:0] lcd_byte;
		logic       slow_command;
		logic       last;
	} lcd_write_t;

	localparam int PRINT_LIMIT = 30;

	logic       cur_row = 1'b0;
	logic [3:0] cur_col = 4'd0;
	lcd_write_t writes_due[$];
	int         fails = 0;
	int         due_count = 0;
	int         chars = 0;
	int         writes = 0;

	assign fail_count     = fails;
	assign writes_pending = due_count;
	assign chars_seen     = chars;
	assign writes_seen    = writes;

	function automatic logic [7:0] ddram_addr(input logic row, input logic [3:0] col);
		return CMD_SET_ADDR | {1'b0, row, 2'b00, col};
	endfunction

	task automatic push_write(input logic is_data, input logic [7:0] b, input logic slow,
			input logic last);
		lcd_write_t w;
		w.is_data      = is_data;
		w.lcd_byte     = b;
		w.slow_command = slow;
		w.last         = last;
		writes_due.push_back(w);
	endtask

	// moves the cursor for one character and queues the writes it causes
	task automatic take_char(input logic [7:0] ch);
		case (ch)
			CH_LF: begin
				cur_row = ~cur_row;
				cur_col = 4'd0;
				push_write(1'b0, ddram_addr(cur_row, cur_col), 1'b0, 1'b1);
			end
			CH_TAB: begin
				cur_col = (cur_col + 4'd4) & 4'b1100;
				push_write(1'b0, ddram_addr(cur_row, cur_col), 1'b0, 1'b1);
			end
			CH_VT: begin
				cur_row = ~cur_row;
				push_write(1'b0, ddram_addr(cur_row, cur_col), 1'b0, 1'b1);
			end
			CH_CR: begin
				cur_col = 4'd0;
				push_write(1'b0, ddram_addr(cur_row, cur_col), 1'b0, 1'b1);
			end
			CH_BS: begin
				if (cur_col != 4'd0)
					cur_col = cur_col - 4'd1;
				push_write(1'b0, ddram_addr(cur_row, cur_col), 1'b0, 1'b0);
				push_write(1'b1, CHAR_SPACE, 1'b0, 1'b0);
				push_write(1'b0, ddram_addr(cur_row, cur_col), 1'b0, 1'b1);
			end
			CH_FF: begin
				cur_row = 1'b0;
				cur_col = 4'd0;
				push_write(1'b0, CMD_CLEAR, 1'b1, 1'b1);
			end
			default: begin
				push_write(1'b1, ch, 1'b0, 1'b1);
				cur_col = cur_col + 4'd1;
			end
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		if (fails < PRINT_LIMIT)
			$display("%0t ns  mismatch: %s", $time, msg);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		lcd_write_t due;
		if (!arst_n) begin
			cur_row = 1'b0;
			cur_col = 4'd0;
			writes_due.delete();
			due_count = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				take_char(s_tdata);
				chars++;
			end
			if (m_tvalid && m_tready) begin
				writes++;
				if (writes_due.size() == 0) begin
					report_mismatch($sformatf("write %02h with nothing outstanding", m_tdata));
				end else begin
					due = writes_due.pop_front();
					if (m_tuser[0] !== due.is_data)
						report_mismatch($sformatf("is_data %b, want %b (byte %02h)",
							m_tuser[0], due.is_data, due.lcd_byte));
					if (m_tdata !== due.lcd_byte)
						report_mismatch($sformatf("lcd_byte %02h, want %02h",
							m_tdata, due.lcd_byte));
					if (m_tuser[1] !== due.slow_command)
						report_mismatch($sformatf("slow_command %b, want %b (byte %02h)",
							m_tuser[1], due.slow_command, due.lcd_byte));
					if (m_tlast !== due.last)
						report_mismatch($sformatf("last %b, want %b (byte %02h)",
							m_tlast, due.last, due.lcd_byte));
				end
			end
			due_count = writes_due.size();
		end
	end

endmodule

// File: test/lcd_control_char_cursor_test.sv
`timescale 1ns / 100ps

module lcd_control_char_cursor_test;
	import lcc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_CHARS   = 150;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic [7:0] s_tdata  = 8'h00;
	logic       m_tready = 1'b1;
	logic       s_tready;
	logic       m_tvalid;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [1:0] m_tuser;

	int fail_count;
	int writes_pending;
	int chars_seen;
	int writes_seen;
	int gap_pct     = 0;
	int stall_pct   = 0;
	int idle_cycles = 0;

	logic [7:0] control_chars [6] = '{CH_BS, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};

	always #5 clk = ~clk;

	lcd_control_char_cursor DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	lcd_write_checker write_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tlast        (m_tlast),
		.m_tuser        (m_tuser),
		.fail_count     (fail_count),
		.writes_pending (writes_pending),
		.chars_seen     (chars_seen),
		.writes_seen    (writes_seen)
	);

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles", idle_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// receiver backpressure in bursts
	initial begin
		forever begin
			@(posedge clk);
			if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [7:0] random_char();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 55)
			return 8'($urandom_range(8'h20, 8'h7E));
		else if (pick < 82)
			return control_chars[$urandom_range(0, 5)];
		else
			return 8'($urandom_range(0, 255));
	endfunction

	task automatic send_char(input logic [7:0] ch);
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'($urandom);
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	initial begin
		// backspace at column 0, byte extremes, tab steps and wrap, row moves, clear
		static logic [7:0] warmup [] = '{
			CH_BS, 8'h00, 8'hFF, CH_BS, CH_TAB, CH_TAB, CH_TAB, 8'h80, 8'h7F, 8'h55,
			CH_TAB, CH_VT, CH_BS, 8'hAA, 8'h41, CH_CR, CH_LF, CH_LF, CH_VT, CH_FF,
			8'h01, CH_BS
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		gap_pct   = 20;
		stall_pct = 10;
		foreach (warmup[k])
			send_char(warmup[k]);

		for (int i = 0; i < RANDOM_CHARS; i++) begin
			case (i)
				0: begin
					gap_pct   = 30;
					stall_pct = 15;
				end
				50: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				80: begin
					gap_pct   = 60;
					stall_pct = 30;
				end
				125: begin
					gap_pct   = 0;
					stall_pct = 0;
				end
				default: ;
			endcase
			send_char(random_char());
		end
		s_tvalid <= 1'b0;

		while (writes_pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d characters sent, %0d lcd writes checked", chars_seen, writes_seen);
		$display("control codes, column and tab wrap, backspace at column 0, idle and stall mix");
		if (fail_count == 0 && writes_pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d writes outstanding", fail_count, writes_pending);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
